/* rtl/hist3d_pkg.sv */
// ----------------------------------------------------------------------------
// hist3d_pkg
// Shared types, codes and constants of the 3D histogram binning accumulator.
// ----------------------------------------------------------------------------
package hist3d_pkg;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

    localparam logic [31:0] RANGE_LOW_RESET  = 32'd0;
    localparam logic [31:0] RANGE_HIGH_RESET = 32'd65536;

    localparam int unsigned BINS_DEFAULT = 8;
    localparam int unsigned IN_BIN_W     = 3;
    localparam int unsigned FLAT_W       = 9;
    // wide enough to compare a bin index port with any bin count (up to 127)
    localparam int unsigned BIN_CMP_W    = 7;

    typedef struct packed {
        logic  issue;
        func_t func;
    } merge_req_t;

    function automatic int unsigned idx_width(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* rtl/histogram_3d_binning_accumulator.sv */
// ----------------------------------------------------------------------------
// histogram_3d_binning_accumulator
// 3D histogram of 32-bit bin counts and a running total. Samples are binned
// per axis in three parallel divider lanes; other operations add to or read
// a given bin.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   s_       s_valid / s_ready    s_func, s_sample_x/y/z, s_bin_x/y/z, s_amount
//   m_       m_valid / m_ready    m_flat_index, m_bin_count, m_total_count
//   cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data (range registers)
//
// A sample waits for all three axis lanes, so its binning ends with the
// bit-serial divider of the slowest lane; add and read do the bin store RMW.
// One item is in flight at a time; the next is taken as soon as the
// previous one has reached the output register.
// After reset the bin store is cleared one entry a cycle, all X*Y*Z entries,
// during which no item is accepted. A stalled result holds the RMW.
// ----------------------------------------------------------------------------
module histogram_3d_binning_accumulator
    import hist3d_pkg::*;
#(
    parameter int unsigned X_BINS = BINS_DEFAULT,
    parameter int unsigned Y_BINS = BINS_DEFAULT,
    parameter int unsigned Z_BINS = BINS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic signed [31:0]   s_sample_x,
    input  logic signed [31:0]   s_sample_y,
    input  logic signed [31:0]   s_sample_z,
    input  logic [IN_BIN_W-1:0]  s_bin_x,
    input  logic [IN_BIN_W-1:0]  s_bin_y,
    input  logic [IN_BIN_W-1:0]  s_bin_z,
    input  logic signed [31:0]   s_amount,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FLAT_W-1:0]    m_flat_index,
    output logic [31:0]          m_bin_count,
    output logic [31:0]          m_total_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned XW = idx_width(X_BINS);
    localparam int unsigned YW = idx_width(Y_BINS);
    localparam int unsigned ZW = idx_width(Z_BINS);

    logic [31:0]          x_low_reg, x_high_reg;
    logic [31:0]          y_low_reg, y_high_reg;
    logic [31:0]          z_low_reg, z_high_reg;

    func_t                func_reg;
    logic [IN_BIN_W-1:0]  bx_in_reg, by_in_reg, bz_in_reg;
    logic [31:0]          amount_reg;
    logic                 wait_lanes_reg;
    logic                 direct_reg;
    logic [2:0]           lane_flags_reg;

    logic                 in_accept;
    logic                 lane_start;
    logic [2:0]           lane_done;
    logic [XW-1:0]        lane_bin_x;
    logic [YW-1:0]        lane_bin_y;
    logic [ZW-1:0]        lane_bin_z;
    logic                 merge_idle;
    merge_req_t           req;
    logic [XW-1:0]        sel_bin_x;
    logic [YW-1:0]        sel_bin_y;
    logic [ZW-1:0]        sel_bin_z;
    logic [BIN_CMP_W-1:0] bx_wide, by_wide, bz_wide;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !wait_lanes_reg && !direct_reg && merge_idle;
    assign in_accept  = s_valid && s_ready;
    assign lane_start = in_accept && (func_t'(s_func) == FUNC_SAMPLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg  <= RANGE_LOW_RESET;
            x_high_reg <= RANGE_HIGH_RESET;
            y_low_reg  <= RANGE_LOW_RESET;
            y_high_reg <= RANGE_HIGH_RESET;
            z_low_reg  <= RANGE_LOW_RESET;
            z_high_reg <= RANGE_HIGH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_X_LOW:  x_low_reg  <= cfg_data;
                REG_X_HIGH: x_high_reg <= cfg_data;
                REG_Y_LOW:  y_low_reg  <= cfg_data;
                REG_Y_HIGH: y_high_reg <= cfg_data;
                REG_Z_LOW:  z_low_reg  <= cfg_data;
                REG_Z_HIGH: z_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_lanes_reg <= 1'b0;
            direct_reg     <= 1'b0;
            lane_flags_reg <= '0;
        end else begin
            if (in_accept) begin
                wait_lanes_reg <= lane_start;
                direct_reg     <= !lane_start;
                lane_flags_reg <= '0;
            end else begin
                if (req.issue) begin
                    wait_lanes_reg <= 1'b0;
                    direct_reg     <= 1'b0;
                end
                lane_flags_reg <= lane_flags_reg | lane_done;
            end
        end
        if (in_accept) begin
            func_reg   <= func_t'(s_func);
            bx_in_reg  <= s_bin_x;
            by_in_reg  <= s_bin_y;
            bz_in_reg  <= s_bin_z;
            amount_reg <= s_amount;
        end
    end

    hist3d_axis_lane #(.BINS(X_BINS)) u_lane_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (lane_start),
        .coord      (s_sample_x),
        .range_low  (x_low_reg),
        .range_high (x_high_reg),
        .done       (lane_done[0]),
        .bin        (lane_bin_x)
    );

    hist3d_axis_lane #(.BINS(Y_BINS)) u_lane_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (lane_start),
        .coord      (s_sample_y),
        .range_low  (y_low_reg),
        .range_high (y_high_reg),
        .done       (lane_done[1]),
        .bin        (lane_bin_y)
    );

    hist3d_axis_lane #(.BINS(Z_BINS)) u_lane_z (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (lane_start),
        .coord      (s_sample_z),
        .range_low  (z_low_reg),
        .range_high (z_high_reg),
        .done       (lane_done[2]),
        .bin        (lane_bin_z)
    );

    // saturate given bin indexes to the last bin of each axis
    assign bx_wide = BIN_CMP_W'(bx_in_reg);
    assign by_wide = BIN_CMP_W'(by_in_reg);
    assign bz_wide = BIN_CMP_W'(bz_in_reg);

    always_comb begin
        if (func_reg == FUNC_SAMPLE) begin
            sel_bin_x = lane_bin_x;
            sel_bin_y = lane_bin_y;
            sel_bin_z = lane_bin_z;
        end else begin
            sel_bin_x = (bx_wide >= BIN_CMP_W'(X_BINS)) ? XW'(X_BINS - 1) : XW'(bx_wide);
            sel_bin_y = (by_wide >= BIN_CMP_W'(Y_BINS)) ? YW'(Y_BINS - 1) : YW'(by_wide);
            sel_bin_z = (bz_wide >= BIN_CMP_W'(Z_BINS)) ? ZW'(Z_BINS - 1) : ZW'(bz_wide);
        end
    end

    assign req.issue = direct_reg || (wait_lanes_reg && (lane_flags_reg == 3'b111));
    assign req.func  = func_reg;

    hist3d_merge #(
        .X_BINS (X_BINS),
        .Y_BINS (Y_BINS),
        .Z_BINS (Z_BINS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .req_bin_x     (sel_bin_x),
        .req_bin_y     (sel_bin_y),
        .req_bin_z     (sel_bin_z),
        .req_amount    (amount_reg),
        .idle          (merge_idle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_flat_index  (m_flat_index),
        .m_bin_count   (m_bin_count),
        .m_total_count (m_total_count)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous one in flight");

    a_issue_to_idle_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        req.issue |-> merge_idle)
        else $error("merge request issued while merge stage busy");

    a_lane_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_done != 3'b000) |-> wait_lanes_reg)
        else $error("axis lane finished with no sample pending");

endmodule

/* rtl/hist3d_axis_lane.sv */
// ----------------------------------------------------------------------------
// hist3d_axis_lane
// Bins one coordinate: floor((v-low)*BINS/(high-low)) clamped to 0..BINS-1,
// by a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hist3d_axis_lane
    import hist3d_pkg::*;
#(
    parameter int unsigned BINS = BINS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [31:0]                coord,
    input  logic [31:0]                range_low,
    input  logic [31:0]                range_high,
    output logic                       done,
    output logic [idx_width(BINS)-1:0] bin
);

    localparam int unsigned QW = idx_width(BINS);
    localparam int unsigned SW = idx_width(QW);
    localparam int unsigned NW = 32 + $clog2(BINS + 1);

    typedef enum logic [1:0] {
        L_IDLE,
        L_PREP,
        L_DIV
    } lane_state_t;

    lane_state_t     state_reg, state_next;
    logic [32:0]     diff_reg, diff_next;
    logic [32:0]     den_reg, den_next;
    logic [NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   dsh_reg, dsh_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            done_reg, done_next;
    logic [QW-1:0]   bin_reg, bin_next;
    logic            take;

    assign take = (rem_reg >= dsh_reg);

    always_comb begin
        state_next = state_reg;
        diff_next  = diff_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        bin_next   = bin_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    diff_next  = {coord[31], coord} - {range_low[31], range_low};
                    den_next   = {range_high[31], range_high} - {range_low[31], range_low};
                    state_next = L_PREP;
                end
            end
            L_PREP: begin
                if (den_reg[32] || (den_reg == 33'd0) || diff_reg[32]) begin
                    // empty range or below the range
                    bin_next   = '0;
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else if (diff_reg >= den_reg) begin
                    bin_next   = QW'(BINS - 1);
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else begin
                    rem_next   = NW'(diff_reg[31:0]) * NW'(BINS);
                    dsh_next   = NW'(den_reg[31:0]) << (QW - 1);
                    quo_next   = '0;
                    step_next  = SW'(QW - 1);
                    state_next = L_DIV;
                end
            end
            L_DIV: begin
                if (take) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = QW'({quo_reg, take});
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0) begin
                    bin_next   = QW'({quo_reg, take});
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        diff_reg <= diff_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        bin_reg  <= bin_next;
    end

    assign done = done_reg;
    assign bin  = bin_reg;

endmodule

/* rtl/hist3d_merge.sv */
// ----------------------------------------------------------------------------
// hist3d_merge
// Combines the three axis bins into a flat index, does the read-modify-write
// of the bin store and the total, holds the result register and clears
// the store after reset.
module hist3d_merge
    import hist3d_pkg::*;
#(
    parameter int unsigned X_BINS = BINS_DEFAULT,
    parameter int unsigned Y_BINS = BINS_DEFAULT,
    parameter int unsigned Z_BINS = BINS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  merge_req_t                   req,
    input  logic [idx_width(X_BINS)-1:0] req_bin_x,
    input  logic [idx_width(Y_BINS)-1:0] req_bin_y,
    input  logic [idx_width(Z_BINS)-1:0] req_bin_z,
    input  logic [31:0]                  req_amount,
    output logic                         idle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [FLAT_W-1:0]            m_flat_index,
    output logic [31:0]                  m_bin_count,
    output logic [31:0]                  m_total_count
);

    localparam int unsigned NUM_BINS = X_BINS * Y_BINS * Z_BINS;
    localparam int unsigned FW       = idx_width(NUM_BINS);

    typedef enum logic [1:0] {
        M_CLEAR,
        M_IDLE,
        M_READ,
        M_UPDATE
    } merge_state_t;

    merge_state_t      state_reg, state_next;
    logic [FW-1:0]     clr_addr_reg, clr_addr_next;
    logic [FW-1:0]     idx_reg, idx_next;
    func_t             func_reg, func_next;
    logic [31:0]       amount_reg, amount_next;
    logic [31:0]       total_reg, total_next;
    logic              out_valid_reg, out_valid_next;
    logic [FLAT_W-1:0] out_flat_reg, out_flat_next;
    logic [31:0]       out_bin_reg, out_bin_next;
    logic [31:0]       out_total_reg, out_total_next;

    logic [31:0]       mem [NUM_BINS];
    logic [31:0]       rdata_reg;
    logic              mem_we;
    logic [FW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;

    logic [FW-1:0]     flat_idx;
    logic [FW+FLAT_W-1:0] flat_ext;
    logic [31:0]       incr;
    logic [31:0]       new_count;

    assign flat_idx = FW'(req_bin_x)
                    + FW'(req_bin_y) * FW'(X_BINS)
                    + FW'(req_bin_z) * FW'(X_BINS * Y_BINS);
    assign flat_ext = (FW + FLAT_W)'(idx_reg);

    always_comb begin
        case (func_reg)
            FUNC_SAMPLE: incr = 32'd1;
            FUNC_ADD:    incr = amount_reg;
            default:     incr = 32'd0;
        endcase
    end

    assign new_count = rdata_reg + incr;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        func_next      = func_reg;
        amount_next    = amount_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_flat_next  = out_flat_reg;
        out_bin_next   = out_bin_reg;
        out_total_next = out_total_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = new_count;
        case (state_reg)
            M_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 32'd0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == FW'(NUM_BINS - 1)) begin
                    state_next = M_IDLE;
                end
            end
            M_IDLE: begin
                if (req.issue) begin
                    idx_next    = flat_idx;
                    func_next   = req.func;
                    amount_next = req_amount;
                    state_next  = M_READ;
                end
            end
            M_READ: begin
                state_next = M_UPDATE;
            end
            M_UPDATE: begin
                // hold until the result register is free
                if (!out_valid_reg || m_ready) begin
                    mem_we         = 1'b1;
                    total_next     = total_reg + incr;
                    out_valid_next = 1'b1;
                    out_flat_next  = flat_ext[FLAT_W-1:0];
                    out_bin_next   = new_count;
                    out_total_next = total_reg + incr;
                    state_next     = M_IDLE;
                end
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= M_CLEAR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg       <= idx_next;
        func_reg      <= func_next;
        amount_reg    <= amount_next;
        out_flat_reg  <= out_flat_next;
        out_bin_reg   <= out_bin_next;
        out_total_reg <= out_total_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    assign idle          = (state_reg == M_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_flat_index  = out_flat_reg;
    assign m_bin_count   = out_bin_reg;
    assign m_total_count = out_total_reg;

endmodule
